// ----- rtl/dltq_pkg.sv -----
// dltq_pkg: types and codes shared by the delta-list timeout queue
// used by dltq_ctrl, dltq_datapath and delta_list_timeout_queue
package dltq_pkg;

  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_INSERT   = 2'd1;
  localparam logic [1:0] CMD_REMOVE   = 2'd2;
  localparam logic [1:0] CMD_DISPATCH = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOHIT = 2'd2;
  localparam logic [1:0] ST_FIRED = 2'd3;

  localparam int OUT_LIMIT = 16;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        handler_id;
    logic [15:0]        argument;
    logic signed [15:0] delay_ticks;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        fired_handler;
    logic [15:0]        fired_argument;
    logic signed [15:0] lateness;
    logic               due_pending;
    logic               last;
  } rsp_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture request, set cursor to head
    logic step;      // advance cursor: prev <= cur, cur <= link[cur]
    logic tick_dec;  // write decremented delta at cursor
    logic ins_link;  // splice new entry at cursor
    logic rem_link;  // unlink entry at cursor
    logic disp_pop;  // pop head into free list
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic cur_nil;
    logic free_nil;
    logic tick_stop;  // decremented value > 0 or == 0
    logic tick_due;   // decremented value <= 0
    logic ins_here;   // delta[cur] >= remaining delay
    logic rem_hit;
    logic head_due;   // head present and delta <= 0
  } dp_sts_t;

endpackage

// ----- rtl/dltq_datapath.sv -----
// dltq_datapath: entry tables, links, list heads and walk cursor
// depends on dltq_pkg
module dltq_datapath #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  dltq_pkg::req_t   req,
  input  dltq_pkg::dp_cmd_t cmd,
  output dltq_pkg::dp_sts_t sts,
  output logic [15:0]      head_handler,
  output logic [15:0]      head_argument,
  output logic signed [15:0] head_late
);
  localparam int LW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);
  localparam logic signed [TIME_BITS-1:0] TMAX = {1'b0, {(TIME_BITS-1){1'b1}}};
  localparam logic signed [TIME_BITS-1:0] TMIN = {1'b1, {(TIME_BITS-1){1'b0}}};

  logic signed [TIME_BITS-1:0] delta_mem [ENTRIES];
  logic [15:0] hnd_mem [ENTRIES];
  logic [15:0] arg_mem [ENTRIES];
  logic [LW-1:0] link [ENTRIES];
  logic [LW-1:0] active_head, free_head, cur, prev;
  logic [15:0] key_h, key_a;
  logic signed [TIME_BITS-1:0] remain;

  logic [IW-1:0] ci, pi, hi, fi;
  assign ci = cur[IW-1:0];
  assign pi = prev[IW-1:0];
  assign hi = active_head[IW-1:0];
  assign fi = free_head[IW-1:0];

  logic signed [TIME_BITS-1:0] dcur, dec, dhead;
  logic signed [TIME_BITS:0] wide;
  assign dcur  = delta_mem[ci];
  assign dhead = delta_mem[hi];
  assign dec   = (dcur == TMIN) ? TMIN : dcur - 1'b1;

  // delay clamp for a new request
  logic signed [TIME_BITS-1:0] dly_c;
  always_comb begin
    if (req.delay_ticks <= 0) dly_c = TIME_BITS'(1);
    else if (32'(signed'(req.delay_ticks)) > 32'(signed'(TMAX))) dly_c = TMAX;
    else dly_c = TIME_BITS'(req.delay_ticks);
  end

  // saturating adjust of the following entry (insert: minus, remove: plus)
  logic [LW-1:0] nxt;
  logic [IW-1:0] ni;
  logic signed [TIME_BITS-1:0] dnxt, adj;
  assign nxt  = link[ci];
  assign ni   = nxt[IW-1:0];
  assign dnxt = cmd.ins_link ? dcur : delta_mem[ni];
  always_comb begin
    if (cmd.ins_link) wide = {dcur[TIME_BITS-1], dcur} - {remain[TIME_BITS-1], remain};
    else wide = {dnxt[TIME_BITS-1], dnxt} + {dcur[TIME_BITS-1], dcur};
    if (wide[TIME_BITS] != wide[TIME_BITS-1]) adj = wide[TIME_BITS] ? TMIN : TMAX;
    else adj = wide[TIME_BITS-1:0];
  end

  always_comb begin
    sts.cur_nil   = (cur == NIL);
    sts.free_nil  = (free_head == NIL);
    sts.tick_stop = (dec >= 0);
    sts.tick_due  = (dec <= 0);
    sts.ins_here  = (dcur >= remain);
    sts.rem_hit   = (hnd_mem[ci] == key_h) && (arg_mem[ci] == key_a);
    sts.head_due  = (active_head != NIL) && (dhead <= 0);
  end

  assign head_handler  = hnd_mem[hi];
  assign head_argument = arg_mem[hi];
  assign head_late = (32'(signed'(dhead)) < -32768) ? 16'sh8000 : 16'(dhead);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) link[i] <= LW'(i + 1);
      active_head <= NIL;
      free_head   <= '0;
      cur  <= NIL;
      prev <= NIL;
    end else begin
      if (cmd.load) begin
        key_h  <= req.handler_id;
        key_a  <= req.argument;
        remain <= dly_c;
        cur    <= active_head;
        prev   <= NIL;
      end
      if (cmd.step) begin
        if (dcur > 0) remain <= remain - dcur;
        prev <= cur;
        cur  <= link[ci];
      end
      if (cmd.tick_dec) delta_mem[ci] <= dec;
      if (cmd.ins_link) begin
        hnd_mem[fi]   <= key_h;
        arg_mem[fi]   <= key_a;
        delta_mem[fi] <= remain;
        link[fi]      <= cur;
        free_head     <= link[fi];
        if (prev != NIL) link[pi] <= free_head;
        else active_head <= free_head;
        if (cur != NIL) delta_mem[ci] <= adj;
      end
      if (cmd.rem_link) begin
        if (nxt != NIL && dcur > 0) delta_mem[ni] <= adj;
        if (prev != NIL) link[pi] <= nxt;
        else active_head <= nxt;
        link[ci]  <= free_head;
        free_head <= cur;
      end
      if (cmd.disp_pop) begin
        active_head <= link[hi];
        link[hi]    <= free_head;
        free_head   <= active_head;
      end
    end
  end
endmodule

// ----- rtl/dltq_ctrl.sv -----
// dltq_ctrl: command sequencer for the timeout queue
// depends on dltq_pkg
module dltq_ctrl #(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        cmd_in,
  input  dltq_pkg::dp_sts_t sts,
  input  logic [15:0]       head_handler,
  input  logic [15:0]       head_argument,
  input  logic signed [15:0] head_late,
  output logic              busy,
  output dltq_pkg::dp_cmd_t cmd,
  output logic              strobe,
  output dltq_pkg::rsp_t    result
);
  localparam logic [2:0] S_IDLE = 3'd0, S_TICK = 3'd1, S_INS = 3'd2,
                         S_REM = 3'd3, S_DISP = 3'd4;
  localparam int SW = $clog2(ENTRIES + 1);
  localparam int KW = $clog2(dltq_pkg::OUT_LIMIT + 1);

  logic [2:0] state, state_next;
  logic [SW-1:0] steps;
  logic [KW-1:0] k;
  logic due;
  logic fire;
  dltq_pkg::rsp_t rsp_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    fire = 1'b0;
    rsp_next = '0;
    rsp_next.last = 1'b1;
    case (state)
      S_IDLE: if (start) begin
        cmd.load = 1'b1;
        case (cmd_in)
          dltq_pkg::CMD_TICK:   state_next = S_TICK;
          dltq_pkg::CMD_INSERT: state_next = S_INS;
          dltq_pkg::CMD_REMOVE: state_next = S_REM;
          default:              state_next = S_DISP;
        endcase
      end
      S_TICK: begin
        if (sts.cur_nil || steps == SW'(ENTRIES)) begin
          fire = 1'b1; rsp_next.due_pending = due; state_next = S_IDLE;
        end else begin
          cmd.tick_dec = 1'b1;
          if (sts.tick_stop) begin
            fire = 1'b1; rsp_next.due_pending = due | sts.tick_due;
            state_next = S_IDLE;
          end else cmd.step = 1'b1;
        end
      end
      S_INS: begin
        if (sts.free_nil) begin
          fire = 1'b1; rsp_next.status = dltq_pkg::ST_FULL; state_next = S_IDLE;
        end else if (sts.cur_nil || steps == SW'(ENTRIES) || sts.ins_here) begin
          cmd.ins_link = 1'b1; fire = 1'b1; state_next = S_IDLE;
        end else cmd.step = 1'b1;
      end
      S_REM: begin
        if (sts.cur_nil || steps == SW'(ENTRIES)) begin
          fire = 1'b1; rsp_next.status = dltq_pkg::ST_NOHIT; state_next = S_IDLE;
        end else if (sts.rem_hit) begin
          cmd.rem_link = 1'b1; fire = 1'b1; state_next = S_IDLE;
        end else cmd.step = 1'b1;
      end
      S_DISP: begin
        fire = 1'b1;
        if (sts.head_due && k != KW'(dltq_pkg::OUT_LIMIT)) begin
          cmd.disp_pop = 1'b1;
          rsp_next.status = dltq_pkg::ST_FIRED;
          rsp_next.fired_handler = head_handler;
          rsp_next.fired_argument = head_argument;
          rsp_next.lateness = head_late;
          rsp_next.last = 1'b0;
        end else if (k != '0) begin
          fire = 1'b0; state_next = S_IDLE;
        end else state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // a dispatch learns its final entry only in the following cycle, so each result is
  // held in a register and the last flag patched when the walk ends
  logic pend;
  logic strobe_next;
  dltq_pkg::rsp_t held, out_next;

  always_comb begin
    strobe_next = 1'b0;
    out_next = rsp_next;
    if (state == S_DISP) begin
      if (pend) begin
        strobe_next = 1'b1;
        out_next = held;
        if (!cmd.disp_pop) out_next.last = 1'b1;
      end else if (!cmd.disp_pop) strobe_next = 1'b1;
    end else strobe_next = fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; pend <= 1'b0; strobe <= 1'b0;
      steps <= '0; k <= '0; due <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        steps <= '0; k <= '0; due <= 1'b0;
      end
      if (cmd.step) begin
        steps <= steps + 1'b1;
        if (state == S_TICK) due <= 1'b1;
      end
      if (cmd.disp_pop) k <= k + 1'b1;
      strobe <= strobe_next;
      if (strobe_next) result <= out_next;
      if (state == S_DISP) begin
        pend <= cmd.disp_pop;
        held <= rsp_next;
      end
    end
  end
endmodule

// ----- rtl/delta_list_timeout_queue.sv -----
// delta_list_timeout_queue: top level of the delta-list timeout queue
// depends on dltq_pkg, dltq_ctrl, dltq_datapath
// walk: tick, insert and remove step the cursor one list link at a time, at most ENTRIES links
// dispatch: one result per cycle per due entry, 16 entries max
// throughput: one transaction at a time, set by the single walk cursor
// reset: synchronous; list empty, all entries chained free; no clearing pass
module delta_list_timeout_queue #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  dltq_pkg::req_t req,
  output logic           busy,
  output logic           strobe,
  output dltq_pkg::rsp_t result
);
  // command and status between the sequencer and the table datapath
  dltq_pkg::dp_cmd_t dcmd;
  dltq_pkg::dp_sts_t dsts;
  logic [15:0] head_handler, head_argument;
  logic signed [15:0] head_late;

  // entry tables, links and walk cursor
  dltq_datapath #(.ENTRIES(ENTRIES), .TIME_BITS(TIME_BITS)) u_dp (
    .clk, .rst, .req, .cmd(dcmd), .sts(dsts),
    .head_handler, .head_argument, .head_late
  );

  // per-transaction walk sequencer; drives the result strobe
  dltq_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk, .rst, .start, .cmd_in(req.cmd), .sts(dsts),
    .head_handler, .head_argument, .head_late,
    .busy, .cmd(dcmd), .strobe, .result
  );
endmodule
